// ----- hw/rtl/radial_gradient_pixel_macros.svh -----
// Assertion macros shared by the radial gradient pixel RTL.
`ifndef RADIAL_GRADIENT_PIXEL_MACROS_SVH
`define RADIAL_GRADIENT_PIXEL_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, reset masks the check.
`define RGP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rgp assertion failed");
// Next-cycle implication, reset masks the check.
`define RGP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rgp assertion failed");
`else
`define RGP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RGP_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- hw/rtl/rgp_pkg.sv -----
// Shared constants and types for the radial gradient pixel pipeline.
`timescale 1ns / 1ps
`default_nettype none
package rgp_pkg;

    localparam int CRD_W         = 10;
    localparam int SIDE_W        = 11;
    localparam int TINT_W        = 8;
    localparam int PIX_W         = 8;
    localparam int IDX_W         = 3;
    localparam int MAX_SIDE      = 1024;
    localparam int CTR_W         = 10;
    localparam int SQ_W          = 2 * CRD_W;
    localparam int SUM_W         = SQ_W + 1;
    localparam int SCALE_W       = 16;
    localparam int FALLOFF_SCALE = 65025;
    localparam int GOAL_W        = SUM_W + SCALE_W;
    localparam int R2_W          = 2 * CTR_W;
    localparam int LEVELS        = PIX_W;
    localparam int MR_W          = R2_W + PIX_W;
    localparam int DIST_STAGES   = 4;
    localparam int PIPE_DEPTH    = DIST_STAGES + LEVELS + 1;
    localparam int RESET_W       = 32;
    localparam int RESET_H       = 32;
    localparam int RESET_RAD     = ((RESET_W < RESET_H) ? RESET_W : RESET_H) / 2;
    localparam int RESET_R2      = RESET_RAD * RESET_RAD;

    typedef enum logic [IDX_W-1:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_RED    = 3'd2,
        REG_GREEN  = 3'd3,
        REG_BLUE   = 3'd4
    } reg_idx_t;

    // Geometry and tint as seen by the datapath.
    typedef struct packed {
        logic [CTR_W-1:0]  cx;
        logic [CTR_W-1:0]  cy;
        logic [R2_W-1:0]   r2;
        logic              rad_zero;
        logic [TINT_W-1:0] tint_r;
        logic [TINT_W-1:0] tint_g;
        logic [TINT_W-1:0] tint_b;
    } geom_t;

    typedef struct packed {
        logic              valid;
        logic [GOAL_W-1:0] goal;
    } dist_t;

    // Partial root search: m holds the largest value found so far with
    // m*m*r2 below goal, prod = m*m*r2 and mr = m*r2.
    typedef struct packed {
        logic [GOAL_W-1:0] goal;
        logic              goal_zero;
        logic [GOAL_W-1:0] prod;
        logic [MR_W-1:0]   mr;
        logic [PIX_W-1:0]  m;
    } root_t;

endpackage
`default_nettype wire

// ----- hw/rtl/rgp_cfg.sv -----
// Configuration registers and derived sprite geometry.
`timescale 1ns / 1ps
`default_nettype none
`include "radial_gradient_pixel_macros.svh"
module rgp_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [rgp_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [rgp_pkg::SIDE_W-1:0]  cfg_data,
    output rgp_pkg::geom_t                   geom
);

    logic [rgp_pkg::SIDE_W-1:0] width_reg, width_next;
    logic [rgp_pkg::SIDE_W-1:0] height_reg, height_next;
    logic [rgp_pkg::TINT_W-1:0] red_reg, red_next;
    logic [rgp_pkg::TINT_W-1:0] green_reg, green_next;
    logic [rgp_pkg::TINT_W-1:0] blue_reg, blue_next;
    logic [rgp_pkg::R2_W-1:0]   r2_reg, r2_next;
    logic [rgp_pkg::SIDE_W-1:0] wl, hl, side_min;
    logic [rgp_pkg::CTR_W-1:0]  rad;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        red_next    = red_reg;
        green_next  = green_reg;
        blue_next   = blue_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (rgp_pkg::reg_idx_t'(cfg_index))
                rgp_pkg::REG_WIDTH:  width_next  = cfg_data;
                rgp_pkg::REG_HEIGHT: height_next = cfg_data;
                rgp_pkg::REG_RED:    red_next    = cfg_data[rgp_pkg::TINT_W-1:0];
                rgp_pkg::REG_GREEN:  green_next  = cfg_data[rgp_pkg::TINT_W-1:0];
                rgp_pkg::REG_BLUE:   blue_next   = cfg_data[rgp_pkg::TINT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp sides, then take centers and radius.
    always_comb
    begin
        wl = (width_reg > rgp_pkg::SIDE_W'(rgp_pkg::MAX_SIDE)) ?
             rgp_pkg::SIDE_W'(rgp_pkg::MAX_SIDE) : width_reg;
        hl = (height_reg > rgp_pkg::SIDE_W'(rgp_pkg::MAX_SIDE)) ?
             rgp_pkg::SIDE_W'(rgp_pkg::MAX_SIDE) : height_reg;
        side_min = (wl < hl) ? wl : hl;
        rad      = rgp_pkg::CTR_W'(side_min >> 1);
        r2_next  = rgp_pkg::R2_W'(rad * rad);
        geom.cx       = rgp_pkg::CTR_W'(wl >> 1);
        geom.cy       = rgp_pkg::CTR_W'(hl >> 1);
        geom.r2       = r2_reg;
        geom.rad_zero = (rad == '0);
        geom.tint_r   = red_reg;
        geom.tint_g   = green_reg;
        geom.tint_b   = blue_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= rgp_pkg::SIDE_W'(rgp_pkg::RESET_W);
            height_reg <= rgp_pkg::SIDE_W'(rgp_pkg::RESET_H);
            red_reg    <= '0;
            green_reg  <= '0;
            blue_reg   <= '0;
            r2_reg     <= rgp_pkg::R2_W'(rgp_pkg::RESET_R2);
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            red_reg    <= red_next;
            green_reg  <= green_next;
            blue_reg   <= blue_next;
            r2_reg     <= r2_next;
        end
    end

    `RGP_ASSERT_NXT(a_red_write, clk, rst_n, cfg_valid && cfg_ready && cfg_index == rgp_pkg::REG_RED, red_reg == $past(cfg_data[rgp_pkg::TINT_W-1:0]))

endmodule
`default_nettype wire

// ----- hw/rtl/rgp_dist.sv -----
// Distance stages: offsets, squares, sum and scaled goal.
`timescale 1ns / 1ps
`default_nettype none
module rgp_dist (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic [rgp_pkg::CRD_W-1:0]  col,
    input  wire logic [rgp_pkg::CRD_W-1:0]  row,
    input  rgp_pkg::geom_t                  geom,
    output rgp_pkg::dist_t                  dist_pkt
);

    logic                          s0_vld_reg, s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic [rgp_pkg::CRD_W-1:0]     dx_reg, dx_next, dy_reg, dy_next;
    logic [rgp_pkg::SQ_W-1:0]      sqx_reg, sqy_reg;
    logic [rgp_pkg::SUM_W-1:0]     sum_reg;
    logic [rgp_pkg::GOAL_W-1:0]    goal_reg;

    always_comb
    begin
        dx_next = (col >= geom.cx) ? (col - geom.cx) : (geom.cx - col);
        dy_next = (row >= geom.cy) ? (row - geom.cy) : (geom.cy - row);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s0_vld_reg <= in_valid;
            s1_vld_reg <= s0_vld_reg;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        sqx_reg  <= rgp_pkg::SQ_W'(dx_reg * dx_reg);
        sqy_reg  <= rgp_pkg::SQ_W'(dy_reg * dy_reg);
        sum_reg  <= rgp_pkg::SUM_W'(sqx_reg) + rgp_pkg::SUM_W'(sqy_reg);
        goal_reg <= rgp_pkg::GOAL_W'(sum_reg) * rgp_pkg::GOAL_W'(rgp_pkg::FALLOFF_SCALE);
    end

    assign dist_pkt.valid = s3_vld_reg;
    assign dist_pkt.goal  = goal_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/rgp_search.sv -----
// Bit-serial root search, one result bit per pipeline stage.
`timescale 1ns / 1ps
`default_nettype none
`include "radial_gradient_pixel_macros.svh"
module rgp_search (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  rgp_pkg::dist_t                 dist_pkt,
    input  wire logic [rgp_pkg::R2_W-1:0]  r2,
    output logic                           out_valid,
    output rgp_pkg::root_t                 root
);

    localparam int LV = rgp_pkg::LEVELS;

    logic           vld_reg [LV];
    rgp_pkg::root_t lvl_reg [LV];
    logic           stg_vld [LV+1];
    rgp_pkg::root_t stg     [LV+1];

    always_comb
    begin
        stg_vld[0]        = dist_pkt.valid;
        stg[0].goal       = dist_pkt.goal;
        stg[0].goal_zero  = (dist_pkt.goal == '0);
        stg[0].prod       = '0;
        stg[0].mr         = '0;
        stg[0].m          = '0;
    end

    for (genvar i = 0; i < LV; i++)
    begin : g_lvl
        localparam int K = LV - 1 - i;
        logic [rgp_pkg::GOAL_W-1:0] cand;
        rgp_pkg::root_t             nxt;

        // Try setting bit K: (m+b)^2*r2 = m^2*r2 + 2*b*m*r2 + b^2*r2.
        always_comb
        begin
            cand = stg[i].prod + (rgp_pkg::GOAL_W'(stg[i].mr) << (K + 1))
                 + (rgp_pkg::GOAL_W'(r2) << (2 * K));
            nxt = stg[i];
            if (cand < stg[i].goal)
            begin
                nxt.prod = cand;
                nxt.mr   = stg[i].mr + (rgp_pkg::MR_W'(r2) << K);
                nxt.m    = stg[i].m | (rgp_pkg::PIX_W'(1) << K);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else
            begin
                vld_reg[i] <= stg_vld[i];
            end
        end

        always_ff @(posedge clk)
        begin
            lvl_reg[i] <= nxt;
        end

        assign stg_vld[i+1] = vld_reg[i];
        assign stg[i+1]     = lvl_reg[i];
    end

    assign out_valid = stg_vld[LV];
    assign root      = stg[LV];

    `RGP_ASSERT_IMP(a_zero_goal_root, clk, rst_n, out_valid && root.goal_zero, root.m == '0)

endmodule
`default_nettype wire

// ----- hw/rtl/radial_gradient_pixel.sv -----
// Top level of the radial gradient sprite pixel generator.
//
//  channel   direction  handshake              payload
//  request   in         start high, busy low   col, row
//  result    out        done strobe, 1 cycle   alpha, red, green, blue
//  config    in         cfg_valid & cfg_ready  cfg_index, cfg_data
//
// One pixel request enters every clock; each result passes through the
// PIPE_DEPTH stages: four distance stages, eight root-search stages
// (one bit of the falloff per stage) and one shading stage.
// busy is never raised; the pipeline does not stall and the receiver cannot
// hold results off, so every request is delivered exactly once.
// Reset clears the valid bits and restores the 32x32 sprite with zero tint.
// Write configuration only while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "radial_gradient_pixel_macros.svh"
module radial_gradient_pixel (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [rgp_pkg::CRD_W-1:0]   col,
    input  wire logic [rgp_pkg::CRD_W-1:0]   row,
    output logic                             done,
    output logic [rgp_pkg::PIX_W-1:0]        alpha,
    output logic [rgp_pkg::PIX_W-1:0]        red,
    output logic [rgp_pkg::PIX_W-1:0]        green,
    output logic [rgp_pkg::PIX_W-1:0]        blue,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [rgp_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [rgp_pkg::SIDE_W-1:0]  cfg_data
);

    rgp_pkg::geom_t              geom;
    rgp_pkg::dist_t              dist_pkt;
    rgp_pkg::root_t              root;
    logic                        root_valid;
    logic [rgp_pkg::PIX_W-1:0]   inten;
    logic                        done_reg;
    logic [rgp_pkg::PIX_W-1:0]   alpha_reg, red_reg, green_reg, blue_reg;
    logic [2*rgp_pkg::PIX_W-1:0] prod_r, prod_g, prod_b;

    // Fully pipelined: never hold off a request.
    assign busy = 1'b0;

    rgp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    rgp_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .col      (col),
        .row      (row),
        .geom     (geom),
        .dist_pkt (dist_pkt)
    );

    rgp_search u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .dist_pkt  (dist_pkt),
        .r2        (geom.r2),
        .out_valid (root_valid),
        .root      (root)
    );

    // The search yields the largest m' with m'^2*r2 below the goal, so the
    // smallest m meeting the goal is m'+1 and the intensity is 254-m'.
    // A zero goal means the center pixel: full intensity. Zero radius
    // forces everything to black.
    always_comb
    begin
        if (geom.rad_zero)
        begin
            inten = '0;
        end
        else if (root.goal_zero)
        begin
            inten = '1;
        end
        else if (root.m >= (rgp_pkg::PIX_W'('1) - rgp_pkg::PIX_W'(1)))
        begin
            inten = '0;
        end
        else
        begin
            inten = rgp_pkg::PIX_W'('1) - rgp_pkg::PIX_W'(1) - root.m;
        end
        prod_r = inten * geom.tint_r;
        prod_g = inten * geom.tint_g;
        prod_b = inten * geom.tint_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= root_valid;
        end
    end

    // Shade: scale each tint by the intensity, keep the high byte.
    always_ff @(posedge clk)
    begin
        alpha_reg <= inten;
        red_reg   <= prod_r[2*rgp_pkg::PIX_W-1:rgp_pkg::PIX_W];
        green_reg <= prod_g[2*rgp_pkg::PIX_W-1:rgp_pkg::PIX_W];
        blue_reg  <= prod_b[2*rgp_pkg::PIX_W-1:rgp_pkg::PIX_W];
    end

    assign done  = done_reg;
    assign alpha = alpha_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

    `RGP_ASSERT_IMP(a_latency, clk, rst_n, start && !busy, ##(rgp_pkg::PIPE_DEPTH) done)
    `RGP_ASSERT_IMP(a_dark_pixel, clk, rst_n, done && alpha == '0, red == '0 && green == '0 && blue == '0)
    `RGP_ASSERT_IMP(a_zero_radius, clk, rst_n, done && geom.rad_zero, alpha == '0)

endmodule
`default_nettype wire

// ----- test/tb_radial_gradient_pixel.sv -----
// Self-checking testbench for the radial gradient sprite pixel generator.
`timescale 1ns / 1ps
module tb_radial_gradient_pixel;
    import rgp_pkg::*;

    // Run shape: a directed opening, then random sprite settings with a
    // burst of pixel requests under each one. The last settings run with no
    // idling on either channel.
    localparam int SHADE_PHASES  = 23;
    localparam int PIXELS_EACH   = 50;
    localparam int QUIET_PHASES  = 2;
    localparam int GAP_LONGEST   = 5;
    localparam int DRAIN_LIMIT   = 200;
    localparam int REPORT_LIMIT  = 10;
    localparam int WATCHDOG_NS   = 400000;

    // Sides that sit at or beyond the legal edges: zero radius, tiny
    // radius, exactly the maximum, and values the block must clamp.
    localparam logic [SIDE_W-1:0] EDGE_SIDES [8] = '{
        11'd0, 11'd1, 11'd2, 11'd3, 11'd1023, 11'd1024, 11'd1025, 11'd2047
    };

    typedef struct packed {
        logic [CRD_W-1:0] col;
        logic [CRD_W-1:0] row;
        logic [PIX_W-1:0] alpha;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } shade_t;

    // Shading predictor: mirrors the register file, works out the expected
    // pixel for every accepted request and checks results in order.
    class gradient_shader;
        logic [SIDE_W-1:0] sprite_w = SIDE_W'(RESET_W);
        logic [SIDE_W-1:0] sprite_h = SIDE_W'(RESET_H);
        logic [PIX_W-1:0]  tint_r   = '0;
        logic [PIX_W-1:0]  tint_g   = '0;
        logic [PIX_W-1:0]  tint_b   = '0;
        shade_t            expected_shades[$];
        int                failures  = 0;
        int                requests  = 0;
        int                reg_writes = 0;
        int                dark_pixels = 0;
        int                full_pixels = 0;

        function void apply_reg_write(logic [IDX_W-1:0] idx, logic [SIDE_W-1:0] data);
            reg_writes++;
            case (idx)
                REG_WIDTH:  sprite_w = data;
                REG_HEIGHT: sprite_h = data;
                REG_RED:    tint_r   = data[PIX_W-1:0];
                REG_GREEN:  tint_g   = data[PIX_W-1:0];
                REG_BLUE:   tint_b   = data[PIX_W-1:0];
                default:    ;
            endcase
        endfunction

        // Smallest m with m*m*L*L >= 65025*S gives intensity 255-m.
        function logic [PIX_W-1:0] intensity_at(logic [CRD_W-1:0] c, logic [CRD_W-1:0] r);
            longint unsigned w, h, rad, dx, dy, goal, r2, m;
            w = (sprite_w > MAX_SIDE) ? MAX_SIDE : sprite_w;
            h = (sprite_h > MAX_SIDE) ? MAX_SIDE : sprite_h;
            rad = ((w < h) ? w : h) >> 1;
            dx = (c >= (w >> 1)) ? c - (w >> 1) : (w >> 1) - c;
            dy = (r >= (h >> 1)) ? r - (h >> 1) : (h >> 1) - r;
            goal = 64'd65025 * (dx * dx + dy * dy);
            r2 = rad * rad;
            if (rad == 0)
                return '0;
            for (m = 0; m < 255; m++)
            begin
                if (m * m * r2 >= goal)
                    return PIX_W'(255 - m);
            end
            return '0;
        endfunction

        function void note_request(logic [CRD_W-1:0] c, logic [CRD_W-1:0] r);
            shade_t      want;
            logic [15:0] prod;
            want.col   = c;
            want.row   = r;
            want.alpha = intensity_at(c, r);
            prod = want.alpha * tint_r;
            want.red = prod[15:8];
            prod = want.alpha * tint_g;
            want.green = prod[15:8];
            prod = want.alpha * tint_b;
            want.blue = prod[15:8];
            if (want.alpha == 0)
                dark_pixels++;
            if (want.alpha == 8'd255)
                full_pixels++;
            requests++;
            expected_shades.push_back(want);
        endfunction

        function void check_result(logic [PIX_W-1:0] a, logic [PIX_W-1:0] r,
                                   logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
            shade_t want;
            if (expected_shades.size() == 0)
            begin
                if (failures < REPORT_LIMIT)
                    $display("ERROR: result a=%0d r=%0d g=%0d b=%0d with no request pending",
                             a, r, g, b);
                failures++;
                return;
            end
            want = expected_shades.pop_front();
            if (a !== want.alpha || r !== want.red || g !== want.green || b !== want.blue)
            begin
                if (failures < REPORT_LIMIT)
                    $display("ERROR: pixel (%0d,%0d) %0dx%0d want a=%0d r=%0d g=%0d b=%0d got a=%0d r=%0d g=%0d b=%0d",
                             want.col, want.row, sprite_w, sprite_h, want.alpha, want.red,
                             want.green, want.blue, a, r, g, b);
                failures++;
            end
        endfunction

        function void flag_leftovers();
            if (expected_shades.size() != 0)
            begin
                $display("ERROR: %0d pixel results never arrived", expected_shades.size());
                failures += expected_shades.size();
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    logic              busy;
    logic [CRD_W-1:0]  col       = '0;
    logic [CRD_W-1:0]  row       = '0;
    logic              done;
    logic [PIX_W-1:0]  alpha;
    logic [PIX_W-1:0]  red;
    logic [PIX_W-1:0]  green;
    logic [PIX_W-1:0]  blue;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [SIDE_W-1:0] cfg_data  = '0;

    gradient_shader shader = new();
    int             settings_seen = 0;

    radial_gradient_pixel uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .col       (col),
        .row       (row),
        .done      (done),
        .alpha     (alpha),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Sample every handshake at the edge that completes it; the values read
    // here are the ones that stood before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                shader.apply_reg_write(cfg_index, cfg_data);
            if (start && !busy)
                shader.note_request(col, row);
            if (done)
                shader.check_result(alpha, red, green, blue);
        end
    end

    // Present one pixel request and hold it until accepted. Maybe drop start
    // for a short burst first, so gaps land on every pipeline stage.
    task automatic send_pixel(input logic [CRD_W-1:0] c, input logic [CRD_W-1:0] r,
                              input bit quiet);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            gap = $urandom_range(1, GAP_LONGEST);
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        col   <= c;
        row   <= r;
        do @(posedge clk); while (busy);
    endtask

    // Drop start and wait for every pending result, then let the pipeline
    // settle a little longer so a stray result would still show up.
    task automatic wait_idle();
        int waited;
        waited = 0;
        start <= 1'b0;
        @(posedge clk);
        while (shader.expected_shades.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    // Hold one register write until the block takes it.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [SIDE_W-1:0] data,
                             input bit quiet);
        int gap;
        if (!quiet && $urandom_range(0, 2) == 0)
        begin
            cfg_valid <= 1'b0;
            gap = $urandom_range(1, GAP_LONGEST);
            repeat (gap) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Apply a whole sprite setting while the pipeline is empty; an unused
    // register index is thrown in now and then and must change nothing.
    task automatic set_sprite(input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] h,
                              input logic [SIDE_W-1:0] tr, input logic [SIDE_W-1:0] tg,
                              input logic [SIDE_W-1:0] tb, input bit quiet);
        wait_idle();
        write_reg(REG_WIDTH, w, quiet);
        write_reg(REG_HEIGHT, h, quiet);
        if ($urandom_range(0, 2) == 0)
            write_reg(IDX_W'($urandom_range(REG_BLUE + 1, (1 << IDX_W) - 1)),
                      SIDE_W'($urandom), quiet);
        write_reg(REG_RED, tr, quiet);
        write_reg(REG_GREEN, tg, quiet);
        write_reg(REG_BLUE, tb, quiet);
        cfg_valid <= 1'b0;
        settings_seen++;
    endtask

    function automatic logic [SIDE_W-1:0] pick_side();
        case ($urandom_range(0, 9))
            0:       return EDGE_SIDES[$urandom_range(0, 7)];
            1, 2, 3: return SIDE_W'($urandom_range(2, 64));
            default: return SIDE_W'($urandom_range(2, MAX_SIDE));
        endcase
    endfunction

    // Tint data carries random upper bits that the block must drop.
    function automatic logic [SIDE_W-1:0] pick_tint();
        logic [PIX_W-1:0] tint;
        case ($urandom_range(0, 7))
            0:       tint = '0;
            1:       tint = '1;
            default: tint = PIX_W'($urandom);
        endcase
        return {3'($urandom), tint};
    endfunction

    // Aim a pixel: mostly inside the sprite, some on the rim where the
    // falloff search ends, and some anywhere in the coordinate range.
    task automatic aim_pixel(output logic [CRD_W-1:0] c, output logic [CRD_W-1:0] r);
        int ew, eh, rad, dx, dy, x, y, pick, swap;
        ew = (shader.sprite_w > MAX_SIDE) ? MAX_SIDE : int'(shader.sprite_w);
        eh = (shader.sprite_h > MAX_SIDE) ? MAX_SIDE : int'(shader.sprite_h);
        rad = ((ew < eh) ? ew : eh) / 2;
        pick = $urandom_range(0, 19);
        if (pick < 3 || ew == 0 || eh == 0)
        begin
            c = CRD_W'($urandom);
            r = CRD_W'($urandom);
        end
        else if (pick < 8 && rad > 0)
        begin
            dy = $urandom_range(0, rad);
            dx = $rtoi($sqrt(real'(rad * rad - dy * dy))) + int'($urandom_range(0, 4)) - 2;
            if (dx < 0)
                dx = 0;
            if ($urandom_range(0, 1) == 1)
            begin
                swap = dx;
                dx = dy;
                dy = swap;
            end
            x = ($urandom_range(0, 1) == 1) ? ew / 2 + dx : ew / 2 - dx;
            y = ($urandom_range(0, 1) == 1) ? eh / 2 + dy : eh / 2 - dy;
            x = (x < 0) ? 0 : (x > 1023) ? 1023 : x;
            y = (y < 0) ? 0 : (y > 1023) ? 1023 : y;
            c = CRD_W'(x);
            r = CRD_W'(y);
        end
        else
        begin
            c = CRD_W'($urandom_range(0, ew - 1));
            r = CRD_W'($urandom_range(0, eh - 1));
        end
    endtask

    initial
    begin
        logic [CRD_W-1:0] c, r;
        bit               quiet;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset sprite: 32x32 with zero tint, so only alpha moves.
        send_pixel(10'd16, 10'd16, 1'b0);
        send_pixel(10'd0, 10'd0, 1'b0);
        send_pixel(10'd1023, 10'd1023, 1'b0);
        send_pixel(10'd0, 10'd1023, 1'b0);
        send_pixel(10'd1023, 10'd0, 1'b0);
        send_pixel(10'd16, 10'd0, 1'b0);

        // Largest sprite, full red, green written above its width, blue at 0x80.
        set_sprite(11'd1024, 11'd1024, 11'h7FF, 11'h100, 11'h080, 1'b0);
        send_pixel(10'd512, 10'd512, 1'b0);
        send_pixel(10'd512, 10'd0, 1'b0);
        send_pixel(10'd0, 10'd512, 1'b0);
        send_pixel(10'd511, 10'd511, 1'b0);
        send_pixel(10'd1023, 10'd1023, 1'b0);
        send_pixel(10'd300, 10'd700, 1'b0);

        // Width above the maximum is clamped; height 3 leaves radius one.
        set_sprite(11'd2047, 11'd3, 11'd255, 11'd255, 11'd255, 1'b0);
        send_pixel(10'd512, 10'd1, 1'b0);
        send_pixel(10'd513, 10'd1, 1'b0);
        send_pixel(10'd512, 10'd0, 1'b0);
        send_pixel(10'd0, 10'd0, 1'b0);

        // Zero radius: even the center must come out dark.
        set_sprite(11'd1, 11'd1024, 11'd255, 11'd255, 11'd255, 1'b0);
        send_pixel(10'd0, 10'd512, 1'b0);
        send_pixel(10'd0, 10'd0, 1'b0);
        set_sprite(11'd0, 11'd0, 11'd200, 11'd100, 11'd50, 1'b0);
        send_pixel(10'd0, 10'd0, 1'b0);
        send_pixel(10'd1023, 10'd1023, 1'b0);

        // Random settings, each followed by a burst of pixels.
        for (int p = 0; p < SHADE_PHASES; p++)
        begin
            quiet = (p >= SHADE_PHASES - QUIET_PHASES);
            set_sprite(pick_side(), pick_side(), pick_tint(), pick_tint(), pick_tint(), quiet);
            for (int i = 0; i < PIXELS_EACH; i++)
            begin
                aim_pixel(c, r);
                send_pixel(c, r, quiet);
            end
        end

        wait_idle();
        shader.flag_leftovers();
        $display("Checked %0d pixel requests over %0d sprite settings, %0d register writes.",
                 shader.requests, settings_seen, shader.reg_writes);
        $display("Pixels at zero intensity: %0d, at full intensity: %0d.",
                 shader.dark_pixels, shader.full_pixels);
        if (shader.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: end the run if the pipeline stops answering.
    initial
    begin
        #(WATCHDOG_NS);
        $display("ERROR: watchdog expired with %0d results pending",
                 shader.expected_shades.size());
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/rgp_pkg.sv
hw/rtl/rgp_cfg.sv
hw/rtl/rgp_dist.sv
hw/rtl/rgp_search.sv
hw/rtl/radial_gradient_pixel.sv
test/tb_radial_gradient_pixel.sv
